// ===== hdl/cspm_pkg.sv =====
// Package for the color sensor period meter.
// Holds the result record type and the fixed constants; depends on nothing.
package cspm_pkg;

  localparam int unsigned CAP_W   = 16;
  localparam int unsigned TICKS_W = 17;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned COLOR_W = 2;

  localparam logic KIND_WRAP    = 1'b0;
  localparam logic KIND_CAPTURE = 1'b1;

  localparam logic [CNT_W-1:0]   CPC_RESET  = 4'd2;
  localparam logic [TICKS_W-1:0] TIMER_SPAN = 17'h10000;

  localparam int unsigned QDEPTH = 3;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 2;

  typedef struct packed {
    logic [COLOR_W-1:0] color_select;
    logic               sample_valid;
    logic [COLOR_W-1:0] sample_color;
    logic [TICKS_W-1:0] sample_ticks;
  } res_t;

endpackage

// ===== hdl/cspm_core.sv =====
// Input register, measurement state and period computation.
// Depends on cspm_pkg.
module cspm_core
  import cspm_pkg::*;
#(
  parameter int unsigned NUM_COLORS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic             kind,
  input  logic [CAP_W-1:0] capture_value,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  output logic             res_valid,
  output res_t             res
);

  logic               s1_valid_r;
  logic               s1_kind_r;
  logic [CAP_W-1:0]   s1_cap_r;
  logic [CNT_W-1:0]   cpc_r;
  logic               wrap_pending_r, wrap_pending_nxt;
  logic [CAP_W-1:0]   last_capture_r, last_capture_nxt;
  logic [CNT_W-1:0]   capture_count_r, capture_count_nxt;
  logic [COLOR_W-1:0] color_index_r, color_index_nxt;

  logic [CNT_W-1:0]   target;
  logic [CNT_W-1:0]   next_count;
  logic [TICKS_W-1:0] delta;
  logic [COLOR_W:0]   color_inc;
  logic               report;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_kind_r <= kind;
      s1_cap_r  <= capture_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpc_r <= CPC_RESET;
    end else if (cfg_wr_en) begin
      cpc_r <= cfg_wr_data;
    end
  end

  always_comb begin
    target     = (cpc_r == '0) ? CNT_W'(1) : cpc_r;
    next_count = capture_count_r + CNT_W'(1);
    report     = (next_count >= target);
    color_inc  = {1'b0, color_index_r} + (COLOR_W+1)'(1);
    if (wrap_pending_r) begin
      delta = {1'b0, s1_cap_r} + TIMER_SPAN - {1'b0, last_capture_r};
    end else begin
      delta = {1'b0, s1_cap_r - last_capture_r};
    end

    wrap_pending_nxt  = wrap_pending_r;
    last_capture_nxt  = last_capture_r;
    capture_count_nxt = capture_count_r;
    color_index_nxt   = color_index_r;
    res.sample_valid  = 1'b0;
    res.sample_color  = '0;
    res.sample_ticks  = '0;

    if (s1_valid_r) begin
      if (s1_kind_r == KIND_WRAP) begin
        wrap_pending_nxt = 1'b1;
      end else begin
        wrap_pending_nxt = 1'b0;
        last_capture_nxt = s1_cap_r;
        if (report) begin
          res.sample_valid  = 1'b1;
          res.sample_color  = color_index_r;
          res.sample_ticks  = delta;
          capture_count_nxt = '0;
          if (color_inc >= (COLOR_W+1)'(NUM_COLORS)) begin
            color_index_nxt = '0;
          end else begin
            color_index_nxt = color_inc[COLOR_W-1:0];
          end
        end else begin
          capture_count_nxt = next_count;
        end
      end
    end
    res.color_select = color_index_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_pending_r  <= 1'b0;
      last_capture_r  <= '0;
      capture_count_r <= '0;
      color_index_r   <= '0;
    end else begin
      wrap_pending_r  <= wrap_pending_nxt;
      last_capture_r  <= last_capture_nxt;
      capture_count_r <= capture_count_nxt;
      color_index_r   <= color_index_nxt;
    end
  end

  assign res_valid = s1_valid_r;

endmodule

// ===== hdl/cspm_out_queue.sv =====
// Small result queue that registers results and absorbs output stalls.
// Depends on cspm_pkg.
module cspm_out_queue
  import cspm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  res_t              push_data,
  input  logic              pop_stall,
  output logic              pop_valid,
  output res_t              pop_data,
  output logic [QCNT_W-1:0] count
);

  res_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              pop;

  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid && !pop_stall;
  assign pop_data  = entry_r[rd_ptr_r];
  assign count     = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/color_sensor_period_meter_top.sv =====
// Color sensor period meter: measures capture-to-capture timer ticks per color filter.
// An accepted request is held in the core's input register, and its result is written into the
// result queue. Throughput is one request per cycle while in_stall is low; the state update
// completes per request, and the three-entry result queue covers the request in flight.
// Synchronous active-low reset clears all measurement state and the queue and sets
// captures_per_color to 2. Depends on cspm_pkg, cspm_core and cspm_out_queue.
module color_sensor_period_meter_top
  import cspm_pkg::*;
#(
  parameter int unsigned NUM_COLORS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [CAP_W-1:0]   in_capture_value,
  input  logic               cfg_wr_en,
  input  logic [CNT_W-1:0]   cfg_wr_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COLOR_W-1:0] out_color_select,
  output logic               out_sample_valid,
  output logic [COLOR_W-1:0] out_sample_color,
  output logic [TICKS_W-1:0] out_sample_ticks
);

  logic              take;
  logic              res_valid;
  res_t              res;
  res_t              q_data;
  logic [QCNT_W-1:0] q_count;
  logic [QCNT_W:0]   in_flight;

  assign in_flight = {1'b0, q_count} + {{QCNT_W{1'b0}}, res_valid};
  assign in_stall  = (in_flight >= (QCNT_W+1)'(QDEPTH));
  assign take      = in_valid && !in_stall;

  cspm_core #(
    .NUM_COLORS(NUM_COLORS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .kind         (in_kind),
    .capture_value(in_capture_value),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .res_valid    (res_valid),
    .res          (res)
  );

  cspm_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid),
    .push_data(res),
    .pop_stall(out_stall),
    .pop_valid(out_valid),
    .pop_data (q_data),
    .count    (q_count)
  );

  assign out_color_select = q_data.color_select;
  assign out_sample_valid = q_data.sample_valid;
  assign out_sample_color = q_data.sample_color;
  assign out_sample_ticks = q_data.sample_ticks;

endmodule

// ===== tb/tb_color_sensor_period_meter_top.sv =====
// Self-checking testbench for color_sensor_period_meter_top: it drives timer wrap and capture
// requests, predicts each result in step with the block, and compares every result field.
// Depends on cspm_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_color_sensor_period_meter_top;
  import cspm_pkg::*;

  localparam int unsigned NUM_COLORS = 4;
  localparam int unsigned IDLE_LIMIT = 1000;

  typedef struct {
    logic             kind;
    logic [CAP_W-1:0] cap;
  } timer_event_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_kind = KIND_WRAP;
  logic [CAP_W-1:0]   in_capture_value = '0;
  logic               cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]   cfg_wr_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COLOR_W-1:0] out_color_select;
  logic               out_sample_valid;
  logic [COLOR_W-1:0] out_sample_color;
  logic [TICKS_W-1:0] out_sample_ticks;

  timer_event_t event_q[$];
  res_t         readings_q[$];

  logic [CNT_W-1:0]   m_cpc = CPC_RESET;
  logic               m_wrap = 1'b0;
  logic [CAP_W-1:0]   m_last = '0;
  logic [CNT_W-1:0]   m_count = '0;
  logic [COLOR_W-1:0] m_color = '0;

  int unsigned in_drv_cnt = 0;
  int unsigned in_acc_cnt = 0;
  int unsigned in_gap = 0;
  int unsigned stall_gap = 0;
  int unsigned idle_cycles = 0;
  int unsigned err_cnt = 0;
  bit          quiet = 1'b0;
  logic [CAP_W-1:0] prev_cap = '0;

  color_sensor_period_meter_top #(
    .NUM_COLORS(NUM_COLORS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_capture_value (in_capture_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_color_select (out_color_select),
    .out_sample_valid (out_sample_valid),
    .out_sample_color (out_sample_color),
    .out_sample_ticks (out_sample_ticks)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic res_t period_step(logic kind, logic [CAP_W-1:0] cap);
    res_t               r;
    logic [CNT_W-1:0]   target;
    logic [CNT_W-1:0]   next_cnt;
    logic [TICKS_W-1:0] span;
    r = '0;
    if (kind == KIND_WRAP) begin
      m_wrap = 1'b1;
    end else begin
      target = (m_cpc == '0) ? 4'd1 : m_cpc;
      next_cnt = m_count + 4'd1;
      if (m_wrap) begin
        span = {1'b0, cap} + TIMER_SPAN - {1'b0, m_last};
      end else begin
        span = {1'b0, cap - m_last};
      end
      if (next_cnt >= target) begin
        r.sample_valid = 1'b1;
        r.sample_color = m_color;
        r.sample_ticks = span;
        m_count = '0;
        if (m_color + 1 >= NUM_COLORS) begin
          m_color = '0;
        end else begin
          m_color = m_color + 2'd1;
        end
      end else begin
        m_count = next_cnt;
      end
      m_wrap = 1'b0;
      m_last = cap;
    end
    r.color_select = m_color;
    return r;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_acc_cnt != in_drv_cnt) begin
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap = in_gap - 1;
    end else if (event_q.size() != 0) begin
      if (!quiet && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        in_gap = $urandom_range(1, 19) - 1;
      end else begin
        in_valid <= 1'b1;
        in_kind <= event_q[0].kind;
        in_capture_value <= event_q[0].cap;
        in_drv_cnt = in_drv_cnt + 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_gap > 0) begin
      out_stall <= 1'b1;
      stall_gap = stall_gap - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_gap = $urandom_range(1, 19) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        void'(event_q.pop_front());
        in_acc_cnt = in_acc_cnt + 1;
        readings_q.push_back(period_step(in_kind, in_capture_value));
      end
      if (out_valid && !out_stall) begin
        if (readings_q.size() == 0) begin
          $error("unexpected result: color_select %0d, sample_valid %0d", out_color_select,
                 out_sample_valid);
          err_cnt++;
        end else begin
          exp_r = readings_q.pop_front();
          if (out_color_select !== exp_r.color_select) begin
            $error("color_select: expected %0d, actual %0d", exp_r.color_select,
                   out_color_select);
            err_cnt++;
          end
          if (out_sample_valid !== exp_r.sample_valid) begin
            $error("sample_valid: expected %0d, actual %0d", exp_r.sample_valid,
                   out_sample_valid);
            err_cnt++;
          end
          if (out_sample_color !== exp_r.sample_color) begin
            $error("sample_color: expected %0d, actual %0d", exp_r.sample_color,
                   out_sample_color);
            err_cnt++;
          end
          if (out_sample_ticks !== exp_r.sample_ticks) begin
            $error("sample_ticks: expected %0d, actual %0d", exp_r.sample_ticks,
                   out_sample_ticks);
            err_cnt++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("tb_color_sensor_period_meter_top: errors");
          $finish;
        end
      end
    end
  end

  task automatic push_event(logic kind, logic [CAP_W-1:0] cap);
    timer_event_t ev;
    ev.kind = kind;
    ev.cap = cap;
    event_q.push_back(ev);
  endtask

  task automatic settle();
    while (event_q.size() != 0 || readings_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_cpc(logic [CNT_W-1:0] value);
    settle();
    repeat (4) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    m_cpc = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_random(int unsigned n);
    logic [CAP_W-1:0] cap;
    int unsigned      pick;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(0, 7);
      case (pick)
        0: cap = '0;
        1: cap = '1;
        2: cap = prev_cap + CAP_W'($urandom_range(0, 3)) - CAP_W'(1);
        default: cap = CAP_W'($urandom);
      endcase
      if ($urandom_range(0, 3) == 0) begin
        push_event(KIND_WRAP, cap);
      end else begin
        push_event(KIND_CAPTURE, cap);
        prev_cap = cap;
      end
    end
  endtask

  initial begin
    logic [CNT_W-1:0] phase_cpc[8];
    phase_cpc = '{4'd1, 4'd15, 4'd0, 4'd4, 4'd0, 4'd0, 4'd7, 4'd2};
    phase_cpc[4] = CNT_W'($urandom);
    phase_cpc[5] = CNT_W'($urandom);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Register at its reset value: extremes, double wrap, underflow and a full color cycle.
    push_event(KIND_CAPTURE, 16'h0000);
    push_event(KIND_CAPTURE, 16'hFFFF);
    push_event(KIND_WRAP, 16'hFFFF);
    push_event(KIND_WRAP, 16'h0000);
    push_event(KIND_CAPTURE, 16'h0000);
    push_event(KIND_WRAP, 16'h5A5A);
    push_event(KIND_CAPTURE, 16'hFFFF);
    push_event(KIND_CAPTURE, 16'h1234);
    push_event(KIND_CAPTURE, 16'h0100);
    push_event(KIND_CAPTURE, 16'h5555);
    push_event(KIND_WRAP, 16'hA5A5);
    push_event(KIND_CAPTURE, 16'h5555);
    push_event(KIND_CAPTURE, 16'hAAAA);
    push_event(KIND_CAPTURE, 16'hAAAA);

    // The register is then lowered below the running count, and set to zero.
    write_cpc(4'd15);
    for (int i = 0; i < 5; i++) begin
      push_event(KIND_CAPTURE, 16'(i * 16'h3001));
    end
    write_cpc(4'd3);
    push_event(KIND_CAPTURE, 16'h7FFF);
    write_cpc(4'd0);
    push_event(KIND_CAPTURE, 16'h8000);
    push_event(KIND_CAPTURE, 16'h0001);

    for (int p = 0; p < 8; p++) begin
      write_cpc(phase_cpc[p]);
      if (p == 7) begin
        quiet = 1'b1;
      end
      run_random(210);
    end

    settle();
    repeat (8) @(negedge clk);
    if (err_cnt == 0) begin
      $display("tb_color_sensor_period_meter_top: clean");
    end else begin
      $display("tb_color_sensor_period_meter_top: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/cspm_pkg.sv
hdl/cspm_core.sv
hdl/cspm_out_queue.sv
hdl/color_sensor_period_meter_top.sv
tb/tb_color_sensor_period_meter_top.sv
